[rtl/core/bpb_pkg.sv]
// ----------------------------------------------------------------------------
// bpb_pkg
// Types, constants and a helper function shared by the branch predictor bank.
// ----------------------------------------------------------------------------
package bpb_pkg;

  localparam int INDEX_BITS_DEF   = 10;
  localparam int HISTORY_BITS_DEF = 10;
  localparam int COUNT_BITS_DEF   = 32;

  localparam int PC_W        = 32;
  localparam int OUT_COUNT_W = 32;
  localparam int NUM_PRED    = 5;

  // Slot of each predictor in the hit vector and in the count array.
  localparam int PRED_ALWAYS   = 0;
  localparam int PRED_BACKWARD = 1;
  localparam int PRED_ONEBIT   = 2;
  localparam int PRED_BIMODAL  = 3;
  localparam int PRED_GSHARE   = 4;

  // A local-table entry packs the 1-bit outcome above the 2-bit bimodal counter.
  localparam int LOCAL_W = 3;
  localparam logic [LOCAL_W-1:0] LOCAL_RESET   = 3'b110;
  localparam logic [1:0]         GSHARE_RESET  = 2'b10;
  localparam logic [1:0]         CTR_MAX       = 2'b11;
  localparam logic [1:0]         CTR_MIN       = 2'b00;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } bpb_state_t;

  typedef struct packed {
    logic                commit;
    logic [NUM_PRED-1:0] hit;
  } bpb_hits_t;

  function automatic logic [1:0] sat2_update(input logic [1:0] ctr, input logic taken);
    logic [1:0] res;
    res = ctr;
    if (taken) begin
      if (ctr != CTR_MAX) res = ctr + 2'd1;
    end else begin
      if (ctr != CTR_MIN) res = ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

[rtl/core/branch_predictor_bank.sv]
// ----------------------------------------------------------------------------
// branch_predictor_bank
// Scores five branch predictors (always taken, backward, 1-bit, bimodal,
// gshare) on a stream of resolved branches and trains them.
//
//   channel  signals                          carries
//   in       in_valid / in_ready              branch_pc, actual_taken
//   out      out_valid / out_ready            pred_*, hits_*
//
// Each branch goes through the table read on the accepting edge, then the
// read-modify-write and commit in S_LOOK. The registered memory read sets that.
// After reset a clearing pass writes every table entry, with in_ready low.
// A result waiting on out_ready does not block the next transfer on the input;
// only the commit of that next branch waits.
// ----------------------------------------------------------------------------
module branch_predictor_bank #(
  parameter int INDEX_BITS   = bpb_pkg::INDEX_BITS_DEF,
  parameter int HISTORY_BITS = bpb_pkg::HISTORY_BITS_DEF,
  parameter int COUNT_BITS   = bpb_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bpb_pkg::PC_W-1:0]          branch_pc,
  input  logic                              actual_taken,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              pred_always,
  output logic                              pred_backward,
  output logic                              pred_onebit,
  output logic                              pred_bimodal,
  output logic                              pred_gshare,
  output logic [bpb_pkg::OUT_COUNT_W-1:0]   hits_always,
  output logic [bpb_pkg::OUT_COUNT_W-1:0]   hits_backward,
  output logic [bpb_pkg::OUT_COUNT_W-1:0]   hits_onebit,
  output logic [bpb_pkg::OUT_COUNT_W-1:0]   hits_bimodal,
  output logic [bpb_pkg::OUT_COUNT_W-1:0]   hits_gshare
);

  localparam logic [INDEX_BITS-1:0] IDX_LAST = '1;

  bpb_pkg::bpb_state_t state, state_next;

  logic [INDEX_BITS-1:0]        clr_idx;
  logic [bpb_pkg::PC_W-1:0]     pc_q;
  logic                         taken_q;
  logic [bpb_pkg::PC_W-1:0]     prev_pc;
  logic [HISTORY_BITS-1:0]      history;
  logic [bpb_pkg::NUM_PRED-1:0] preds;

  logic                         accept;
  logic                         commit;
  logic                         clearing;
  logic [INDEX_BITS-1:0]        hist_idx;
  logic [INDEX_BITS-1:0]        in_idx;
  logic [INDEX_BITS-1:0]        q_idx;
  logic [bpb_pkg::LOCAL_W-1:0]  rd_local;
  logic [1:0]                   rd_gshare;
  logic [bpb_pkg::NUM_PRED-1:0] cur_pred;
  logic                         wr_en;
  logic [INDEX_BITS-1:0]        wr_idx;
  logic [INDEX_BITS-1:0]        wr_gidx;
  logic [bpb_pkg::LOCAL_W-1:0]  wr_local;
  logic [1:0]                   wr_gshare;
  bpb_pkg::bpb_hits_t           hits;

  logic [bpb_pkg::NUM_PRED-1:0][COUNT_BITS-1:0]          counts;
  logic [bpb_pkg::NUM_PRED-1:0][bpb_pkg::OUT_COUNT_W-1:0] counts_out;

  // Only the low INDEX_BITS of history join the gshare index.
  generate
    if (HISTORY_BITS >= INDEX_BITS) begin : g_hist_wide
      assign hist_idx = history[INDEX_BITS-1:0];
    end else begin : g_hist_narrow
      assign hist_idx = {{(INDEX_BITS-HISTORY_BITS){1'b0}}, history};
    end
  endgenerate

  assign in_idx = branch_pc[INDEX_BITS+1:2];
  assign q_idx  = pc_q[INDEX_BITS+1:2];

  always_ff @(posedge clk) begin
    if (rst) state <= bpb_pkg::S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    commit     = 1'b0;
    clearing   = 1'b0;
    case (state)
      bpb_pkg::S_CLEAR: begin
        clearing = 1'b1;
        if (clr_idx == IDX_LAST) state_next = bpb_pkg::S_IDLE;
      end
      bpb_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = bpb_pkg::S_LOOK;
      end
      bpb_pkg::S_LOOK: begin
        if (!out_valid || out_ready) begin
          commit     = 1'b1;
          state_next = bpb_pkg::S_IDLE;
        end
      end
      default: state_next = bpb_pkg::S_CLEAR;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) clr_idx <= '0;
    else if (clearing) clr_idx <= clr_idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pc_q    <= branch_pc;
      taken_q <= actual_taken;
    end
  end

  // Predictions from the state as it stood before this branch.
  always_comb begin
    cur_pred = '0;
    cur_pred[bpb_pkg::PRED_ALWAYS]   = 1'b1;
    cur_pred[bpb_pkg::PRED_BACKWARD] = pc_q < prev_pc;
    cur_pred[bpb_pkg::PRED_ONEBIT]   = rd_local[2];
    cur_pred[bpb_pkg::PRED_BIMODAL]  = rd_local[1];
    cur_pred[bpb_pkg::PRED_GSHARE]   = rd_gshare[1];
  end

  always_comb begin
    hits.commit = commit;
    for (int k = 0; k < bpb_pkg::NUM_PRED; k++) hits.hit[k] = cur_pred[k] == taken_q;
  end

  // History changes only at commit, so the gshare index is the same at read
  // and at write-back.
  always_comb begin
    wr_en = clearing || commit;
    if (clearing) begin
      wr_idx    = clr_idx;
      wr_gidx   = clr_idx;
      wr_local  = bpb_pkg::LOCAL_RESET;
      wr_gshare = bpb_pkg::GSHARE_RESET;
    end else begin
      wr_idx    = q_idx;
      wr_gidx   = q_idx ^ hist_idx;
      wr_local  = {taken_q, bpb_pkg::sat2_update(rd_local[1:0], taken_q)};
      wr_gshare = bpb_pkg::sat2_update(rd_gshare, taken_q);
    end
  end

  bpb_tables #(
    .INDEX_BITS (INDEX_BITS)
  ) u_tables (
    .clk       (clk),
    .rd_en     (accept),
    .rd_idx    (in_idx),
    .rd_gidx   (in_idx ^ hist_idx),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx),
    .wr_gidx   (wr_gidx),
    .wr_local  (wr_local),
    .wr_gshare (wr_gshare),
    .rd_local  (rd_local),
    .rd_gshare (rd_gshare)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
      prev_pc <= '0;
    end else if (commit) begin
      history <= HISTORY_BITS'({history, taken_q});
      prev_pc <= pc_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (commit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (commit) preds <= cur_pred;
  end

  bpb_score #(
    .COUNT_BITS (COUNT_BITS)
  ) u_score (
    .clk    (clk),
    .rst    (rst),
    .hits   (hits),
    .counts (counts)
  );

  // Counts change only at commit, which waits for the previous result to
  // leave, so the output shows them directly.
  generate
    for (genvar k = 0; k < bpb_pkg::NUM_PRED; k++) begin : g_out
      if (COUNT_BITS >= bpb_pkg::OUT_COUNT_W) begin : g_trunc
        assign counts_out[k] = counts[k][bpb_pkg::OUT_COUNT_W-1:0];
      end else begin : g_ext
        assign counts_out[k] = {{(bpb_pkg::OUT_COUNT_W-COUNT_BITS){1'b0}}, counts[k]};
      end
    end
  endgenerate

  assign pred_always   = preds[bpb_pkg::PRED_ALWAYS];
  assign pred_backward = preds[bpb_pkg::PRED_BACKWARD];
  assign pred_onebit   = preds[bpb_pkg::PRED_ONEBIT];
  assign pred_bimodal  = preds[bpb_pkg::PRED_BIMODAL];
  assign pred_gshare   = preds[bpb_pkg::PRED_GSHARE];
  assign hits_always   = counts_out[bpb_pkg::PRED_ALWAYS];
  assign hits_backward = counts_out[bpb_pkg::PRED_BACKWARD];
  assign hits_onebit   = counts_out[bpb_pkg::PRED_ONEBIT];
  assign hits_bimodal  = counts_out[bpb_pkg::PRED_BIMODAL];
  assign hits_gshare   = counts_out[bpb_pkg::PRED_GSHARE];

  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == bpb_pkg::S_LOOK)
    else $error("accepted branch did not start a table lookup");

  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid && prev_pc == $past(pc_q))
    else $error("commit did not present a result and record the branch");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> !$past(commit) || $past(state) == bpb_pkg::S_LOOK)
    else $error("result overwritten while stalled");

  a_clear_closed: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input open before the clearing pass");

endmodule

[rtl/core/bpb_tables.sv]
// ----------------------------------------------------------------------------
// bpb_tables
// The two predictor memories: the PC-indexed local table (last outcome and
// bimodal counter) and the gshare counter table. One registered read port and
// one write port each.
// ----------------------------------------------------------------------------
module bpb_tables #(
  parameter int INDEX_BITS = bpb_pkg::INDEX_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [INDEX_BITS-1:0]        rd_idx,
  input  logic [INDEX_BITS-1:0]        rd_gidx,
  input  logic                         wr_en,
  input  logic [INDEX_BITS-1:0]        wr_idx,
  input  logic [INDEX_BITS-1:0]        wr_gidx,
  input  logic [bpb_pkg::LOCAL_W-1:0]  wr_local,
  input  logic [1:0]                   wr_gshare,
  output logic [bpb_pkg::LOCAL_W-1:0]  rd_local,
  output logic [1:0]                   rd_gshare
);

  localparam int DEPTH = 1 << INDEX_BITS;

  logic [bpb_pkg::LOCAL_W-1:0] local_mem  [DEPTH];
  logic [1:0]                  gshare_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      local_mem[wr_idx]   <= wr_local;
      gshare_mem[wr_gidx] <= wr_gshare;
    end
  end

  // Read data holds between reads, so a stalled lookup keeps its operands.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_local  <= local_mem[rd_idx];
      rd_gshare <= gshare_mem[rd_gidx];
    end
  end

endmodule

[rtl/core/bpb_score.sv]
// ----------------------------------------------------------------------------
// bpb_score
// Five saturating counters of correct predictions, each bumped on a commit that its predictor got right.
// ----------------------------------------------------------------------------
module bpb_score #(
  parameter int COUNT_BITS = bpb_pkg::COUNT_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  bpb_pkg::bpb_hits_t                            hits,
  output logic [bpb_pkg::NUM_PRED-1:0][COUNT_BITS-1:0]  counts
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
    end else if (hits.commit) begin
      for (int k = 0; k < bpb_pkg::NUM_PRED; k++) begin
        if (hits.hit[k] && counts[k] != COUNT_MAX) counts[k] <= counts[k] + 1'b1;
      end
    end
  end

  a_always_bump: assert property (@(posedge clk) disable iff (rst)
    hits.commit && hits.hit[bpb_pkg::PRED_ALWAYS] &&
    counts[bpb_pkg::PRED_ALWAYS] != COUNT_MAX
    |=> counts[bpb_pkg::PRED_ALWAYS] == $past(counts[bpb_pkg::PRED_ALWAYS]) + 1'b1)
    else $error("always-taken count did not advance on a hit");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !hits.commit |=> $stable(counts))
    else $error("hit counts moved without a commit");

  a_saturate: assert property (@(posedge clk) disable iff (rst)
    counts[bpb_pkg::PRED_GSHARE] == COUNT_MAX |=> counts[bpb_pkg::PRED_GSHARE] == COUNT_MAX)
    else $error("gshare count wrapped past its maximum");

endmodule
